>>> sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, entry and memory request types, and compare operand codes
// for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

    localparam int CAPACITY     = 1024;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 16;

    // heap positions run 1..CAPACITY, memory addresses 0..CAPACITY-1
    localparam int POS_W   = $clog2(CAPACITY + 1);
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CHILD_W = POS_W + 1;

    localparam int OCC_BITS = 11;

    localparam int S_DATA_W    = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W  = KEY_BITS + PAYLOAD_BITS + 1 + OCC_BITS + 1;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_ERR_BIT   = KEY_BITS + PAYLOAD_BITS;
    localparam int M_OCC_LSB   = M_ERR_BIT + 1;
    localparam int M_EMPTY_BIT = M_OCC_LSB + OCC_BITS;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

    typedef enum logic [1:0] {
        CMP_UP,
        CMP_SEL,
        CMP_DOWN
    } cmp_sel_t;

endpackage

`default_nettype wire

>>> sv/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Priority queue of key/payload entries kept as a 1-based binary min-heap in
// a dual-read memory, sifted by a small sequencer around one shared compare.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-----------
//  s_ req   | in  | item_key, item_payload                      | req_type
//  m_ res   | out | out_key, out_payload, req_error, occupancy, | out_valid
//           |     | heap_empty, zero pad                        |
//
//  One item is in work at a time; s_tready is high only while the sequencer
//  is idle. A push climbs one level per parent compare and a pop sinks one
//  level per child select and compare, paced by the registered memory reads
//  and the single comparator. An item can be accepted while the previous
//  result still waits on m_tready.
//  Synchronous active-low reset empties the heap; the memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_queue (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request item
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [31:0] item_key, [47:32] item_payload
    input  wire logic [bmhq_pkg::S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                          s_tuser,
    // result item
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] out_key, [47:32] out_payload, [48] req_error,
    // [59:49] occupancy, [60] heap_empty, [63:61] zero
    output logic [bmhq_pkg::M_DATA_W-1:0]      m_tdata,
    // [0] out_valid
    output logic                               m_tuser
);
    import bmhq_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_POP_RD = 7'b0000010,
        ST_UP_CMP = 7'b0000100,
        ST_DN_SEL = 7'b0001000,
        ST_DN_CMP = 7'b0010000,
        ST_WR_MOV = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // heap position (1-based) to memory address
    function automatic logic [ADDR_W-1:0] pos_addr(input logic [CHILD_W-1:0] p);
        logic [CHILD_W-1:0] a;
        a = p - 1'b1;
        return a[ADDR_W-1:0];
    endfunction

    state_t             state_reg,     state_next;
    logic [POS_W-1:0]   count_reg,     count_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [POS_W-1:0]   chld_pos_reg,  chld_pos_next;
    entry_t             mov_reg,       mov_next;
    entry_t             chld_reg,      chld_next;
    logic               res_valid_reg, res_valid_next;
    entry_t             res_entry_reg, res_entry_next;
    logic               res_err_reg,   res_err_next;
    logic               m_tvalid_reg,  m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic               m_tuser_reg;

    mem_req_t           mreq;
    entry_t             rd_a;
    entry_t             rd_b;
    cmp_sel_t           cmp_sel;
    logic               cmp_less;

    entry_t             in_entry;
    logic [POS_W-1:0]   push_pos;
    logic [POS_W-1:0]   parent;
    logic [CHILD_W-1:0] left;
    logic [CHILD_W-1:0] right;
    logic [CHILD_W-1:0] gl;
    logic [CHILD_W-1:0] size_w;
    logic               out_load;
    logic [M_DATA_W-1:0] out_word;

    bmhq_mem u_mem (
        .aclk (aclk),
        .req  (mreq),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    bmhq_cmp u_cmp (
        .sel      (cmp_sel),
        .mov_key  (mov_reg.key),
        .rda_key  (rd_a.key),
        .rdb_key  (rd_b.key),
        .chld_key (chld_reg.key),
        .less     (cmp_less)
    );

    assign in_entry.key     = s_tdata[KEY_BITS-1:0];
    assign in_entry.payload = s_tdata[KEY_BITS+PAYLOAD_BITS-1:KEY_BITS];

    assign push_pos = count_reg + 1'b1;
    assign parent   = pos_reg >> 1;
    assign left     = {pos_reg, 1'b0};
    assign right    = left + 1'b1;
    assign gl       = {chld_pos_reg, 1'b0};
    assign size_w   = CHILD_W'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        chld_pos_next  = chld_pos_reg;
        mov_next       = mov_reg;
        chld_next      = chld_reg;
        res_valid_next = res_valid_reg;
        res_entry_next = res_entry_reg;
        res_err_next   = res_err_reg;
        mreq.we        = 1'b0;
        mreq.waddr     = pos_addr(CHILD_W'(pos_reg));
        mreq.wdata     = mov_reg;
        mreq.raddr_a   = '0;
        mreq.raddr_b   = '0;
        cmp_sel        = CMP_UP;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_PUSH) begin
                        res_valid_next = 1'b0;
                        res_entry_next = '0;
                        if (count_reg == POS_W'(CAPACITY)) begin
                            // full: drop the entry
                            res_err_next = 1'b1;
                            state_next   = ST_DONE;
                        end else begin
                            res_err_next = 1'b0;
                            count_next   = push_pos;
                            pos_next     = push_pos;
                            mov_next     = in_entry;
                            if (count_reg == '0) begin
                                state_next = ST_WR_MOV;
                            end else begin
                                mreq.raddr_a = pos_addr(CHILD_W'(push_pos >> 1));
                                state_next   = ST_UP_CMP;
                            end
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_valid_next = 1'b0;
                            res_entry_next = '0;
                            res_err_next   = 1'b1;
                            state_next     = ST_DONE;
                        end else begin
                            // fetch root and last entry
                            mreq.raddr_a = '0;
                            mreq.raddr_b = pos_addr(CHILD_W'(count_reg));
                            state_next   = ST_POP_RD;
                        end
                    end
                end
            end

            ST_POP_RD: begin
                res_valid_next = 1'b1;
                res_entry_next = rd_a;
                res_err_next   = 1'b0;
                mov_next       = rd_b;
                count_next     = count_reg - 1'b1;
                pos_next       = POS_W'(1);
                if (count_reg > POS_W'(2)) begin
                    mreq.raddr_a = pos_addr(CHILD_W'(2));
                    mreq.raddr_b = pos_addr(CHILD_W'(3));
                    state_next   = ST_DN_SEL;
                end else if (count_reg == POS_W'(2)) begin
                    state_next = ST_WR_MOV;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_UP_CMP: begin
                cmp_sel = CMP_UP;
                mreq.we = 1'b1;
                if (cmp_less) begin
                    // pull parent down into the hole
                    mreq.wdata = rd_a;
                    pos_next   = parent;
                    if (parent == POS_W'(1)) begin
                        state_next = ST_WR_MOV;
                    end else begin
                        mreq.raddr_a = pos_addr(CHILD_W'(parent >> 1));
                    end
                end else begin
                    mreq.wdata = mov_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DN_SEL: begin
                cmp_sel = CMP_SEL;
                if ((right <= size_w) && cmp_less) begin
                    chld_next     = rd_b;
                    chld_pos_next = right[POS_W-1:0];
                end else begin
                    chld_next     = rd_a;
                    chld_pos_next = left[POS_W-1:0];
                end
                state_next = ST_DN_CMP;
            end

            ST_DN_CMP: begin
                cmp_sel = CMP_DOWN;
                mreq.we = 1'b1;
                if (cmp_less) begin
                    // lift child into the hole
                    mreq.wdata = chld_reg;
                    pos_next   = chld_pos_reg;
                    if (gl <= size_w) begin
                        mreq.raddr_a = pos_addr(gl);
                        mreq.raddr_b = pos_addr(gl + 1'b1);
                        state_next   = ST_DN_SEL;
                    end else begin
                        state_next = ST_WR_MOV;
                    end
                end else begin
                    mreq.wdata = mov_reg;
                    state_next = ST_DONE;
                end
            end

            ST_WR_MOV: begin
                mreq.we    = 1'b1;
                mreq.wdata = mov_reg;
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign out_word = M_DATA_W'({(count_reg == '0), OCC_BITS'(count_reg), res_err_reg,
                                 res_entry_reg.payload, res_entry_reg.key});

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        chld_pos_reg  <= chld_pos_next;
        mov_reg       <= mov_next;
        chld_reg      <= chld_next;
        res_valid_reg <= res_valid_next;
        res_entry_reg <= res_entry_next;
        res_err_reg   <= res_err_next;
        if (out_load) begin
            m_tdata_reg <= out_word;
            m_tuser_reg <= res_valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(CAPACITY))
        else $error("heap count above capacity");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while a request is in work");

    a_pop_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[M_ERR_BIT])
        else $error("returned entry flagged as error");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_EMPTY_BIT] == (m_tdata[M_EMPTY_BIT-1:M_OCC_LSB] == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

`default_nettype wire

>>> sv/bmhq_mem.sv
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap entry storage: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_mem (
    input  wire logic               aclk,
    input  wire bmhq_pkg::mem_req_t req,
    output bmhq_pkg::entry_t        rd_a,
    output bmhq_pkg::entry_t        rd_b
);
    import bmhq_pkg::*;

    entry_t mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_a <= mem[req.raddr_a];
        rd_b <= mem[req.raddr_b];
    end

endmodule

`default_nettype wire

>>> sv/bmhq_cmp.sv
// ----------------------------------------------------------------------------
// bmhq_cmp
// Shared key comparator with operand select for sift-up, child select and
// sift-down steps.
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_cmp (
    input  wire bmhq_pkg::cmp_sel_t              sel,
    input  wire logic [bmhq_pkg::KEY_BITS-1:0]   mov_key,
    input  wire logic [bmhq_pkg::KEY_BITS-1:0]   rda_key,
    input  wire logic [bmhq_pkg::KEY_BITS-1:0]   rdb_key,
    input  wire logic [bmhq_pkg::KEY_BITS-1:0]   chld_key,
    output logic                                 less
);
    import bmhq_pkg::*;

    logic [KEY_BITS-1:0] op_a;
    logic [KEY_BITS-1:0] op_b;

    always_comb begin
        unique case (sel)
            CMP_UP: begin
                op_a = mov_key;
                op_b = rda_key;
            end
            CMP_SEL: begin
                op_a = rdb_key;
                op_b = rda_key;
            end
            CMP_DOWN: begin
                op_a = chld_key;
                op_b = mov_key;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign less = (op_a < op_b);

endmodule

`default_nettype wire
